### design/sbf_pkg.sv
package sbf_pkg;

	localparam int BAN_ENTRIES_DEF   = 1024;
	localparam int TRACK_ENTRIES_DEF = 1024;

	localparam logic [15:0] DNS_PORT_RST = 16'd53;
	localparam logic [15:0] ETYPE_V4     = 16'h0800;
	localparam logic [15:0] ETYPE_V6     = 16'h86DD;

	localparam logic [7:0] PROTO_ICMP  = 8'd1;
	localparam logic [7:0] PROTO_TCP   = 8'd6;
	localparam logic [7:0] PROTO_UDP   = 8'd17;
	localparam logic [7:0] PROTO_ICMP6 = 8'd58;

	localparam logic [15:0] LEN_ETH = 16'd14;
	localparam logic [15:0] LEN_V4  = 16'd20;
	localparam logic [15:0] LEN_V6  = 16'd40;
	localparam logic [15:0] LEN_UDP = 16'd8;
	localparam logic [15:0] LEN_TCP = 16'd20;

	localparam logic [63:0] LO32_MASK = 64'h0000_0000_FFFF_FFFF;

	// ban entry: {tag[2:0], addr_hi, addr_lo}; tag bit0 permanent, bit1 recent, bit2 IPv6
	localparam int BAN_W = 3 + 64 + 64;
	// track entry: {fam, addr_hi, addr_lo, count, stamp}
	localparam int TRK_W = 1 + 64 + 64 + 64 + 64;

	typedef enum logic [2:0] {
		MODE_PKT      = 3'd0,
		MODE_ADD_PERM = 3'd1,
		MODE_ADD_REC  = 3'd2,
		MODE_DEL_PERM = 3'd3,
		MODE_DEL_REC  = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		R_SHORT_ETH  = 4'd0,
		R_OTHER      = 4'd1,
		R_UNLISTED   = 4'd2,
		R_PERM       = 4'd3,
		R_REC_UDP    = 4'd4,
		R_REC_ICMP   = 4'd5,
		R_REC_TCP    = 4'd6,
		R_REC_OTHER  = 4'd7,
		R_DNS        = 4'd8,
		R_LOOPBACK   = 4'd9,
		R_OP_OK      = 4'd10,
		R_FULL       = 4'd11
	} reason_t;

	typedef enum logic [1:0] {
		OP_EARLY = 2'd0,
		OP_PKT   = 2'd1,
		OP_ADD   = 2'd2,
		OP_DEL   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RK_NONE = 2'd0,
		RK_UDP  = 2'd1,
		RK_ICMP = 2'd2,
		RK_TCP  = 2'd3
	} rkind_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_BSCAN = 3'd1,
		ST_BDEC  = 3'd2,
		ST_TSCAN = 3'd3,
		ST_TDEC  = 3'd4
	} state_t;

	typedef struct packed {
		op_t         op;
		logic        recent;
		logic        count_proc;
		reason_t     early_reason;
		logic        fam;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        rec_dns;
		rkind_t      rkind;
	} cmd_t;

endpackage

### design/sbf_ram.sv
module sbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/sbf_front.sv
module sbf_front import sbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] frame_len,
	input  logic [15:0] ethertype,
	input  logic [7:0]  l3_proto,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic        addr_is_v6,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic        tcp_fin,
	input  logic        tcp_rst,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);

	logic [15:0] dns_q;
	cmd_t        c;
	cmd_t        fifo_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        fam;
	logic        l3_ok;
	logic        udp_ok;
	logic        tcp_ok;
	logic [63:0] nhi;
	logic [63:0] nlo;
	logic [7:0]  icmp;

	assign cfg_ready = 1'b1;
	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rptr_q];

	always_comb begin
		fam    = (mode == MODE_PKT) ? (ethertype == ETYPE_V6) : addr_is_v6;
		l3_ok  = fam ? (frame_len >= LEN_ETH + LEN_V6) : (frame_len >= LEN_ETH + LEN_V4);
		udp_ok = fam ? (frame_len >= LEN_ETH + LEN_V6 + LEN_UDP)
			: (frame_len >= LEN_ETH + LEN_V4 + LEN_UDP);
		tcp_ok = fam ? (frame_len >= LEN_ETH + LEN_V6 + LEN_TCP)
			: (frame_len >= LEN_ETH + LEN_V4 + LEN_TCP);
		nhi    = fam ? addr_hi : 64'd0;
		nlo    = fam ? addr_lo : (addr_lo & LO32_MASK);
		icmp   = fam ? PROTO_ICMP6 : PROTO_ICMP;

		c              = '0;
		c.op           = OP_EARLY;
		c.early_reason = R_OP_OK;
		c.fam          = fam;
		c.hi           = nhi;
		c.lo           = nlo;
		c.rec_dns      = (l3_proto == PROTO_UDP) && udp_ok && (dst_port == dns_q);
		if (l3_proto == PROTO_UDP) begin
			c.rkind = RK_UDP;
		end else if (l3_proto == icmp) begin
			c.rkind = RK_ICMP;
		end else if ((l3_proto == PROTO_TCP) && tcp_ok && (tcp_fin || tcp_rst)) begin
			c.rkind = RK_TCP;
		end else begin
			c.rkind = RK_NONE;
		end

		case (mode)
			MODE_PKT: begin
				if (frame_len < LEN_ETH) begin
					c.early_reason = R_SHORT_ETH;
				end else begin
					c.count_proc = 1'b1;
					if ((ethertype != ETYPE_V4 && ethertype != ETYPE_V6) || !l3_ok) begin
						c.early_reason = R_OTHER;
					end else if (fam && l3_proto == PROTO_UDP && udp_ok &&
							(dst_port == dns_q || src_port == dns_q)) begin
						c.early_reason = R_DNS;
					end else if (fam && nhi == 64'd0 && nlo == 64'd1) begin
						c.early_reason = R_LOOPBACK;
					end else begin
						c.op = OP_PKT;
					end
				end
			end
			MODE_ADD_PERM: c.op = OP_ADD;
			MODE_ADD_REC: begin
				c.op     = OP_ADD;
				c.recent = 1'b1;
			end
			MODE_DEL_PERM: c.op = OP_DEL;
			MODE_DEL_REC: begin
				c.op     = OP_DEL;
				c.recent = 1'b1;
			end
			default: c.op = OP_EARLY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_q  <= DNS_PORT_RST;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (cfg_valid) begin
				dns_q <= cfg_data;
			end
			if (push) begin
				fifo_q[wptr_q] <= c;
				wptr_q         <= ~wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

### design/sbf_back.sv
module sbf_back import sbf_pkg::*; #(
	parameter int BAN_ENTRIES   = BAN_ENTRIES_DEF,
	parameter int TRACK_ENTRIES = TRACK_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        verdict,
	output logic [3:0]  reason,
	output logic        promoted,
	output logic [63:0] processed_count,
	output logic [63:0] dropped_count,
	output logic [63:0] hit_count,
	output logic [63:0] source_drop_count
);

	localparam int BAW = $clog2(BAN_ENTRIES);
	localparam int BCW = $clog2(BAN_ENTRIES + 1);
	localparam int TAW = $clog2(TRACK_ENTRIES);
	localparam int TCW = $clog2(TRACK_ENTRIES + 1);
	localparam int SW  = (BCW > TCW) ? BCW : TCW;

	state_t      state_q, state_d;
	cmd_t        cmd_q;
	logic [SW-1:0]  scan_q;
	logic           pend_s1;
	logic [SW-1:0]  ridx_s1;
	logic [BCW-1:0] bfill_q;
	logic [TCW-1:0] tfill_q;
	logic           found_q;
	logic [BAW-1:0] m_idx_q;
	logic [2:0]     m_tag_q;
	logic           free_found_q;
	logic [BAW-1:0] free_idx_q;
	logic           tfound_q;
	logic [TAW-1:0] t_idx_q;
	logic [63:0]    t_cnt_q;
	logic [TAW-1:0] lru_idx_q;
	logic [63:0]    lru_st_q;
	logic [63:0]    stamp_q;
	logic [63:0]    hit_q [4];
	logic [63:0]    proc_q;
	logic [63:0]    drop_q;
	logic           out_valid_q;
	logic           res_verdict_q;
	reason_t        res_reason_q;
	logic           res_promoted_q;
	logic [63:0]    res_hit_q;
	logic [63:0]    res_sdc_q;

	logic [SW-1:0]  limit;
	logic           issue;
	logic           scan_done;
	logic           ban_we, ban_re, trk_we, trk_re;
	logic [BAW-1:0] ban_waddr;
	logic [BAN_W-1:0] ban_wdata, ban_rdata;
	logic [TAW-1:0] trk_waddr;
	logic [TRK_W-1:0] trk_wdata, trk_rdata;
	logic [2:0]     mask;
	logic           bmatch, bfree, tmatch;
	logic           perm_hit, promote, track_needed, bfull, add_at_fill;
	logic [1:0]     hidx;
	logic [63:0]    hit_new;
	logic [63:0]    new_cnt;
	logic           t_new_fill;
	reason_t        dec_reason;

	assign out_valid         = out_valid_q;
	assign verdict           = res_verdict_q;
	assign reason            = res_reason_q;
	assign promoted          = res_promoted_q;
	assign processed_count   = proc_q;
	assign dropped_count     = drop_q;
	assign hit_count         = res_hit_q;
	assign source_drop_count = res_sdc_q;

	sbf_ram #(.WIDTH(BAN_W), .DEPTH(BAN_ENTRIES)) u_ban_ram (
		.clk   (clk),
		.we    (ban_we),
		.waddr (ban_waddr),
		.wdata (ban_wdata),
		.re    (ban_re),
		.raddr (scan_q[BAW-1:0]),
		.rdata (ban_rdata)
	);

	sbf_ram #(.WIDTH(TRK_W), .DEPTH(TRACK_ENTRIES)) u_trk_ram (
		.clk   (clk),
		.we    (trk_we),
		.waddr (trk_waddr),
		.wdata (trk_wdata),
		.re    (trk_re),
		.raddr (scan_q[TAW-1:0]),
		.rdata (trk_rdata)
	);

	always_comb begin
		limit     = (state_q == ST_BSCAN) ? SW'(bfill_q) : SW'(tfill_q);
		issue     = (state_q == ST_BSCAN || state_q == ST_TSCAN) && (scan_q < limit);
		scan_done = (state_q == ST_BSCAN || state_q == ST_TSCAN) && !issue && !pend_s1;
		ban_re    = (state_q == ST_BSCAN) && issue;
		trk_re    = (state_q == ST_TSCAN) && issue;

		bmatch = pend_s1 && (state_q == ST_BSCAN) && (ban_rdata[129:128] != 2'b00) &&
			(ban_rdata[130] == cmd_q.fam) && (ban_rdata[127:64] == cmd_q.hi) &&
			(ban_rdata[63:0] == cmd_q.lo);
		bfree  = pend_s1 && (state_q == ST_BSCAN) && (ban_rdata[129:128] == 2'b00);
		tmatch = pend_s1 && (state_q == ST_TSCAN) && (trk_rdata[256] == cmd_q.fam) &&
			(trk_rdata[255:192] == cmd_q.hi) && (trk_rdata[191:128] == cmd_q.lo);

		mask        = cmd_q.recent ? 3'b010 : 3'b001;
		perm_hit    = found_q && m_tag_q[0];
		promote     = found_q && !m_tag_q[0] && !cmd_q.rec_dns && (cmd_q.rkind != RK_NONE);
		track_needed = (cmd_q.op == OP_PKT) && (perm_hit || promote);
		add_at_fill = !found_q && !free_found_q && (bfill_q != BCW'(BAN_ENTRIES));
		bfull       = !found_q && !free_found_q && (bfill_q == BCW'(BAN_ENTRIES));
		hidx        = {cmd_q.fam, ~m_tag_q[0]};
		hit_new     = hit_q[hidx] + 64'd1;

		// table write for add, remove and promotion
		ban_we    = 1'b0;
		ban_waddr = m_idx_q;
		ban_wdata = {m_tag_q, cmd_q.hi, cmd_q.lo};
		if (state_q == ST_BDEC) begin
			case (cmd_q.op)
				OP_ADD: begin
					if (found_q) begin
						ban_we    = 1'b1;
						ban_wdata = {m_tag_q | mask, cmd_q.hi, cmd_q.lo};
					end else if (free_found_q || add_at_fill) begin
						ban_we    = 1'b1;
						ban_waddr = free_found_q ? free_idx_q : bfill_q[BAW-1:0];
						ban_wdata = {{cmd_q.fam, 2'b00} | mask, cmd_q.hi, cmd_q.lo};
					end
				end
				OP_DEL: begin
					ban_we    = found_q;
					ban_wdata = {m_tag_q & ~mask, cmd_q.hi, cmd_q.lo};
				end
				OP_PKT: begin
					ban_we    = promote;
					ban_wdata = {m_tag_q[2], 2'b01, cmd_q.hi, cmd_q.lo};
				end
				default: ban_we = 1'b0;
			endcase
		end

		case (cmd_q.op)
			OP_ADD: dec_reason = bfull ? R_FULL : R_OP_OK;
			OP_PKT: begin
				if (!found_q) begin
					dec_reason = R_UNLISTED;
				end else if (m_tag_q[0]) begin
					dec_reason = R_PERM;
				end else if (cmd_q.rec_dns) begin
					dec_reason = R_DNS;
				end else begin
					case (cmd_q.rkind)
						RK_UDP:  dec_reason = R_REC_UDP;
						RK_ICMP: dec_reason = R_REC_ICMP;
						RK_TCP:  dec_reason = R_REC_TCP;
						default: dec_reason = R_REC_OTHER;
					endcase
				end
			end
			default: dec_reason = R_OP_OK;
		endcase

		t_new_fill = !tfound_q && (tfill_q != TCW'(TRACK_ENTRIES));
		new_cnt    = tfound_q ? t_cnt_q + 64'd1 : 64'd1;
		trk_we     = (state_q == ST_TDEC);
		trk_waddr  = tfound_q ? t_idx_q : (t_new_fill ? tfill_q[TAW-1:0] : lru_idx_q);
		trk_wdata  = {cmd_q.fam, cmd_q.hi, cmd_q.lo, new_cnt, stamp_q};
	end

	// next state and pop
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !out_valid_q) begin
					cmd_pop = 1'b1;
					state_d = (cmd.op == OP_EARLY) ? ST_IDLE : ST_BSCAN;
				end
			end
			ST_BSCAN: if (scan_done) state_d = ST_BDEC;
			ST_BDEC:  state_d = track_needed ? ST_TSCAN : ST_IDLE;
			ST_TSCAN: if (scan_done) state_d = ST_TDEC;
			ST_TDEC:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q          <= '0;
			scan_q         <= '0;
			pend_s1        <= 1'b0;
			ridx_s1        <= '0;
			bfill_q        <= '0;
			tfill_q        <= '0;
			found_q        <= 1'b0;
			m_idx_q        <= '0;
			m_tag_q        <= '0;
			free_found_q   <= 1'b0;
			free_idx_q     <= '0;
			tfound_q       <= 1'b0;
			t_idx_q        <= '0;
			t_cnt_q        <= '0;
			lru_idx_q      <= '0;
			lru_st_q       <= '0;
			stamp_q        <= '0;
			hit_q          <= '{default: '0};
			proc_q         <= '0;
			drop_q         <= '0;
			out_valid_q    <= 1'b0;
			res_verdict_q  <= 1'b0;
			res_reason_q   <= R_OP_OK;
			res_promoted_q <= 1'b0;
			res_hit_q      <= '0;
			res_sdc_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q        <= cmd;
						proc_q       <= proc_q + {63'd0, cmd.count_proc};
						scan_q       <= '0;
						pend_s1      <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						tfound_q     <= 1'b0;
						if (cmd.op == OP_EARLY) begin
							res_verdict_q  <= 1'b0;
							res_reason_q   <= cmd.early_reason;
							res_promoted_q <= 1'b0;
							res_hit_q      <= '0;
							res_sdc_q      <= '0;
							out_valid_q    <= 1'b1;
						end
					end
				end
				ST_BSCAN: begin
					if (issue) begin
						scan_q <= scan_q + SW'(1);
					end
					pend_s1 <= issue;
					ridx_s1 <= scan_q;
					if (bmatch && !found_q) begin
						found_q <= 1'b1;
						m_idx_q <= ridx_s1[BAW-1:0];
						m_tag_q <= ban_rdata[130:128];
					end
					if (bfree && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= ridx_s1[BAW-1:0];
					end
				end
				ST_BDEC: begin
					scan_q         <= '0;
					pend_s1        <= 1'b0;
					res_verdict_q  <= (cmd_q.op == OP_PKT) && (perm_hit ||
						(promote && (cmd_q.rkind == RK_UDP || cmd_q.rkind == RK_ICMP)));
					res_reason_q   <= dec_reason;
					res_promoted_q <= (cmd_q.op == OP_PKT) && promote;
					res_hit_q      <= ((cmd_q.op == OP_PKT) && found_q) ? hit_new : 64'd0;
					res_sdc_q      <= '0;
					if ((cmd_q.op == OP_PKT) && found_q) begin
						hit_q[hidx] <= hit_new;
					end
					if (track_needed) begin
						drop_q <= drop_q + 64'd1;
					end else begin
						out_valid_q <= 1'b1;
					end
					if ((cmd_q.op == OP_ADD) && add_at_fill) begin
						bfill_q <= bfill_q + BCW'(1);
					end
				end
				ST_TSCAN: begin
					if (issue) begin
						scan_q <= scan_q + SW'(1);
					end
					pend_s1 <= issue;
					ridx_s1 <= scan_q;
					if (tmatch && !tfound_q) begin
						tfound_q <= 1'b1;
						t_idx_q  <= ridx_s1[TAW-1:0];
						t_cnt_q  <= trk_rdata[127:64];
					end
					// oldest stamp marks the least recently used source
					if (pend_s1 && (ridx_s1 == '0 || trk_rdata[63:0] < lru_st_q)) begin
						lru_idx_q <= ridx_s1[TAW-1:0];
						lru_st_q  <= trk_rdata[63:0];
					end
				end
				ST_TDEC: begin
					stamp_q     <= stamp_q + 64'd1;
					res_sdc_q   <= new_cnt;
					out_valid_q <= 1'b1;
					if (t_new_fill) begin
						tfill_q <= tfill_q + TCW'(1);
					end
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

endmodule

### design/source_ban_packet_filter.sv
// Source ban filter for parsed packet headers.
// Input channel (in_valid/in_stall): one item is a packet header (mode 0) or a
// ban table operation (modes 1-4: add permanent, add recent, remove permanent,
// remove recent). Output channel (out_valid/out_stall): exactly one result per
// item, in order: verdict, reason, promoted flag and the running counters.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the DNS port; write it
// only while the block is idle. cfg_ready is always high.
// A front stage classifies each item and parks it in a two-item queue; the
// back engine scans the ban table memory one entry a cycle, then for a
// counted drop scans the drop tracker memory one entry a cycle.
// Items decided by the header alone go from the queue to the result register;
// the others also wait for the ban scan and, for a counted drop, the tracker scan,
// which cover the ban and tracker slots used so far (up to BAN_ENTRIES, TRACK_ENTRIES).
// The memory scans set the throughput, one item at a time in the back engine.
// Reset clears counters and fill counts, not the marks; no clearing pass is needed.
// When the receiver stalls the result holds; the queue takes up to two more
// items, then in_stall rises.
module source_ban_packet_filter import sbf_pkg::*; #(
	parameter int BAN_ENTRIES   = BAN_ENTRIES_DEF,
	parameter int TRACK_ENTRIES = TRACK_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [15:0] frame_len,
	input  logic [15:0] ethertype,
	input  logic [7:0]  l3_proto,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic        addr_is_v6,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic        tcp_fin,
	input  logic        tcp_rst,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        verdict,
	output logic [3:0]  reason,
	output logic        promoted,
	output logic [63:0] processed_count,
	output logic [63:0] dropped_count,
	output logic [63:0] hit_count,
	output logic [63:0] source_drop_count
);

	// classified item travelling from front to back
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	sbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.frame_len  (frame_len),
		.ethertype  (ethertype),
		.l3_proto   (l3_proto),
		.addr_hi    (addr_hi),
		.addr_lo    (addr_lo),
		.addr_is_v6 (addr_is_v6),
		.src_port   (src_port),
		.dst_port   (dst_port),
		.tcp_fin    (tcp_fin),
		.tcp_rst    (tcp_rst),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	// table engine: ban scan, decision, drop tracking, result register
	sbf_back #(
		.BAN_ENTRIES   (BAN_ENTRIES),
		.TRACK_ENTRIES (TRACK_ENTRIES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.verdict           (verdict),
		.reason            (reason),
		.promoted          (promoted),
		.processed_count   (processed_count),
		.dropped_count     (dropped_count),
		.hit_count         (hit_count),
		.source_drop_count (source_drop_count)
	);

endmodule

### design/sbf_checker.sv
module sbf_checker import sbf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        verdict,
	input logic [3:0]  reason,
	input logic        promoted,
	input logic [63:0] source_drop_count,
	input logic [63:0] hit_count
);

	// a held result keeps its reason
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reason))
		else $error("result changed while stalled");

	// drops come only from permanent, recent UDP or recent ICMP hits
	a_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict |-> (reason == R_PERM || reason == R_REC_UDP ||
			reason == R_REC_ICMP))
		else $error("drop with wrong reason");

	// promotion only on a recent hit that counted a drop
	a_promote: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && promoted |-> (reason == R_REC_UDP || reason == R_REC_ICMP ||
			reason == R_REC_TCP) && (source_drop_count != 64'd0))
		else $error("bad promotion");

	// no table hit reported for an unlisted source
	a_unlisted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reason == R_UNLISTED |-> hit_count == 64'd0 && !verdict)
		else $error("unlisted source with hit");

endmodule

bind source_ban_packet_filter sbf_checker u_sbf_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.verdict           (verdict),
	.reason            (reason),
	.promoted          (promoted),
	.source_drop_count (source_drop_count),
	.hit_count         (hit_count)
);

### tb/source_ban_packet_filter_tb.sv
module source_ban_packet_filter_tb import sbf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBAN       = BAN_ENTRIES_DEF;
	localparam int NTRACK     = TRACK_ENTRIES_DEF;
	localparam int POOL       = 25;
	localparam longint LIMIT  = 20000000;

	// One header or table operation, as the block takes it
	typedef struct {
		logic [2:0]  mode;
		logic [15:0] flen;
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        v6;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        fin;
		logic        rst;
	} hdr_t;

	// One filter decision with its counters
	typedef struct {
		logic        verdict;
		reason_t     reason;
		logic        promoted;
		logic [63:0] processed;
		logic [63:0] dropped;
		logic [63:0] hits;
		logic [63:0] src_drops;
	} decision_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [2:0] mode = '0;
	logic [15:0] frame_len = '0, ethertype = '0, src_port = '0, dst_port = '0;
	logic [7:0] l3_proto = '0;
	logic [63:0] addr_hi = '0, addr_lo = '0;
	logic addr_is_v6 = 0, tcp_fin = 0, tcp_rst = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [15:0] cfg_data = '0;
	logic out_valid, out_stall = 0;
	logic verdict, promoted;
	logic [3:0] reason;
	logic [63:0] processed_count, dropped_count, hit_count, source_drop_count;

	source_ban_packet_filter uut (.*);

	always #4 clk = ~clk;

	// Shadow copy of the ban table, drop tracker and counters
	logic [63:0] ban_hi [NBAN];
	logic [63:0] ban_lo [NBAN];
	logic [2:0]  ban_tag [NBAN];
	logic [63:0] trk_hi [NTRACK];
	logic [63:0] trk_lo [NTRACK];
	logic [63:0] trk_cnt [NTRACK];
	logic [1:0]  trk_vf [NTRACK];
	int          trk_age [NTRACK];
	logic [63:0] class_hits [4];
	logic [63:0] processed_tot, dropped_tot;
	logic [15:0] dns_port;

	decision_t pending[$];
	int        errors = 0;
	longint    cycles = 0;

	// Sender burst shaping and receiver stall pattern
	int  burst_left = 0;
	bit  no_gaps = 0;
	int  hold_cycles = 0;
	int  stall_phase = 0;
	bit  stall_on = 0;

	// Source address pool; the last slot is the IPv6 loopback
	logic [63:0] pool_hi [POOL];
	logic [63:0] pool_lo [POOL];
	logic        pool_v6 [POOL];

	function automatic int ban_lookup(logic [63:0] hi, logic [63:0] lo, logic fam);
		for (int i = 0; i < NBAN; i++)
			if (ban_tag[i][1:0] != 0 && ban_tag[i][2] == fam && ban_hi[i] == hi &&
			    ban_lo[i] == lo)
				return i;
		return NBAN;
	endfunction

	function automatic int ban_slot();
		for (int i = 0; i < NBAN; i++)
			if (ban_tag[i][1:0] == 0)
				return i;
		return NBAN;
	endfunction

	// Count one drop for a source; LRU replacement when the tracker is full
	function automatic logic [63:0] count_drop(logic [63:0] hi, logic [63:0] lo, logic fam);
		int e;
		int old;
		e = NTRACK;
		for (int i = 0; i < NTRACK; i++)
			if (trk_vf[i][0] && trk_vf[i][1] == fam && trk_hi[i] == hi && trk_lo[i] == lo) begin
				e = i;
				break;
			end
		if (e < NTRACK) begin
			old = trk_age[e];
			trk_cnt[e] += 1;
		end else begin
			for (int i = 0; i < NTRACK; i++)
				if (!trk_vf[i][0]) begin
					e = i;
					break;
				end
			if (e < NTRACK) begin
				old = NTRACK;
			end else begin
				e = 0;
				for (int i = 1; i < NTRACK; i++)
					if (trk_age[i] > trk_age[e])
						e = i;
				old = trk_age[e];
			end
			trk_hi[e] = hi;
			trk_lo[e] = lo;
			trk_cnt[e] = 1;
		end
		for (int i = 0; i < NTRACK; i++)
			if (i != e && trk_vf[i][0] && trk_age[i] < old)
				trk_age[i]++;
		trk_age[e] = 0;
		trk_vf[e] = {fam, 1'b1};
		return trk_cnt[e];
	endfunction

	function automatic decision_t filter_decide(hdr_t h);
		decision_t d;
		logic [63:0] hi, lo;
		logic fam, udp_ok, tcp_ok;
		logic [2:0] bitm;
		logic [7:0] icmp;
		logic [15:0] l3;
		int e;
		d = '{verdict: 0, reason: R_OP_OK, promoted: 0, processed: 0, dropped: 0,
			hits: 0, src_drops: 0};
		hi = h.hi;
		lo = h.lo;
		if (h.mode != MODE_PKT) begin
			fam = h.v6;
			if (!fam) begin
				hi = '0;
				lo &= LO32_MASK;
			end
			if (h.mode == MODE_ADD_PERM || h.mode == MODE_ADD_REC) begin
				bitm = (h.mode == MODE_ADD_PERM) ? 3'b001 : 3'b010;
				e = ban_lookup(hi, lo, fam);
				if (e >= NBAN) begin
					e = ban_slot();
					if (e < NBAN) begin
						ban_hi[e] = hi;
						ban_lo[e] = lo;
						ban_tag[e] = {fam, 2'b00};
					end
				end
				if (e < NBAN)
					ban_tag[e] |= bitm;
				else
					d.reason = R_FULL;
			end else if (h.mode == MODE_DEL_PERM || h.mode == MODE_DEL_REC) begin
				bitm = (h.mode == MODE_DEL_PERM) ? 3'b001 : 3'b010;
				e = ban_lookup(hi, lo, fam);
				if (e < NBAN)
					ban_tag[e] &= ~bitm;
			end
		end else if (h.flen < LEN_ETH) begin
			d.reason = R_SHORT_ETH;
		end else begin
			processed_tot += 1;
			fam = (h.etype == ETYPE_V6);
			l3 = fam ? LEN_V6 : LEN_V4;
			if ((h.etype != ETYPE_V4 && h.etype != ETYPE_V6) ||
			    32'(h.flen) < 32'(LEN_ETH) + 32'(l3)) begin
				d.reason = R_OTHER;
			end else begin
				udp_ok = 32'(h.flen) >= 32'(LEN_ETH) + 32'(l3) + 32'(LEN_UDP);
				tcp_ok = 32'(h.flen) >= 32'(LEN_ETH) + 32'(l3) + 32'(LEN_TCP);
				if (!fam) begin
					hi = '0;
					lo &= LO32_MASK;
				end
				if (fam && h.proto == PROTO_UDP && udp_ok &&
				    (h.dport == dns_port || h.sport == dns_port)) begin
					d.reason = R_DNS;
				end else if (fam && hi == 0 && lo == 1) begin
					d.reason = R_LOOPBACK;
				end else begin
					e = ban_lookup(hi, lo, fam);
					if (e >= NBAN) begin
						d.reason = R_UNLISTED;
					end else if (ban_tag[e][0]) begin
						class_hits[fam * 2] += 1;
						d.hits = class_hits[fam * 2];
						dropped_tot += 1;
						d.src_drops = count_drop(hi, lo, fam);
						d.verdict = 1;
						d.reason = R_PERM;
					end else begin
						icmp = fam ? PROTO_ICMP6 : PROTO_ICMP;
						class_hits[fam * 2 + 1] += 1;
						d.hits = class_hits[fam * 2 + 1];
						if (h.proto == PROTO_UDP && udp_ok && h.dport == dns_port) begin
							d.reason = R_DNS;
						end else if (h.proto == PROTO_UDP || h.proto == icmp ||
						             (h.proto == PROTO_TCP && tcp_ok && (h.fin | h.rst))) begin
							// promote: recent mark becomes permanent
							ban_tag[e] = (ban_tag[e] | 3'b001) & ~3'b010;
							d.promoted = 1;
							dropped_tot += 1;
							d.src_drops = count_drop(hi, lo, fam);
							if (h.proto == PROTO_UDP) begin
								d.verdict = 1;
								d.reason = R_REC_UDP;
							end else if (h.proto == icmp) begin
								d.verdict = 1;
								d.reason = R_REC_ICMP;
							end else begin
								d.reason = R_REC_TCP;
							end
						end else begin
							d.reason = R_REC_OTHER;
						end
					end
				end
			end
		end
		d.processed = processed_tot;
		d.dropped = dropped_tot;
		return d;
	endfunction

	// Clock counter with a hard stop
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: long hold when asked, otherwise alternate between clean
	// stretches and random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			if (stall_phase == 0) begin
				stall_on <= 1'($urandom_range(0, 1));
				stall_phase <= $urandom_range(20, 120);
			end else begin
				stall_phase <= stall_phase - 1;
			end
			out_stall <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b0;
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
			errors++;
		end
	endfunction

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		decision_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$display("%0t: result with no item outstanding, reason %0d", $realtime, reason);
				errors++;
			end else begin
				w = pending.pop_front();
				check_field("verdict", 64'(w.verdict), 64'(verdict));
				check_field("reason", 64'(w.reason), 64'(reason));
				check_field("promoted", 64'(w.promoted), 64'(promoted));
				check_field("processed_count", w.processed, processed_count);
				check_field("dropped_count", w.dropped, dropped_count);
				check_field("hit_count", w.hits, hit_count);
				check_field("source_drop_count", w.src_drops, source_drop_count);
			end
		end
	end

	// Offer one item, hold it through stalls, predict on acceptance
	task automatic send_item(hdr_t h);
		if (burst_left == 0) begin
			if (!no_gaps) begin
				in_valid = 0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid = 1;
		mode = h.mode;
		frame_len = h.flen;
		ethertype = h.etype;
		l3_proto = h.proto;
		addr_hi = h.hi;
		addr_lo = h.lo;
		addr_is_v6 = h.v6;
		src_port = h.sport;
		dst_port = h.dport;
		tcp_fin = h.fin;
		tcp_rst = h.rst;
		do
			@(posedge clk);
		while (in_stall);
		pending.push_back(filter_decide(h));
		@(negedge clk);
	endtask

	task automatic go_idle();
		in_valid = 0;
		burst_left = 0;
		wait (pending.size() == 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_dns_port(logic [15:0] port);
		go_idle();
		cfg_valid = 1;
		cfg_data = port;
		do
			@(posedge clk);
		while (!cfg_ready);
		dns_port = port;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic hdr_t mk(logic [2:0] m, logic [15:0] fl, logic [15:0] et,
		logic [7:0] pr, logic [63:0] hi, logic [63:0] lo, logic v6);
		hdr_t h;
		h = '{mode: m, flen: fl, etype: et, proto: pr, hi: hi, lo: lo, v6: v6,
			sport: 16'd1000, dport: 16'd2000, fin: 0, rst: 0};
		return h;
	endfunction

	// Random item drawn from the address pool; most are packets, the rest
	// churn the ban marks so hits and promotions keep happening
	function automatic hdr_t rand_item();
		hdr_t h;
		int k;
		k = $urandom_range(0, POOL - 1);
		h.hi = pool_hi[k];
		h.lo = pool_lo[k];
		h.v6 = pool_v6[k];
		if (!pool_v6[k]) begin
			// upper address bits are ignored for IPv4, so fill them with noise
			h.hi = {$urandom, $urandom};
			h.lo[63:32] = $urandom;
		end
		h.fin = 1'($urandom);
		h.rst = 1'($urandom);
		h.sport = ($urandom_range(0, 4) == 0) ? dns_port : 16'($urandom);
		h.dport = ($urandom_range(0, 3) == 0) ? dns_port : 16'($urandom);
		h.flen = 16'($urandom_range(100, 1500));
		h.etype = h.v6 ? ETYPE_V6 : ETYPE_V4;
		h.proto = PROTO_UDP;
		if ($urandom_range(0, 9) < 3) begin
			h.mode = 3'($urandom_range(1, 4));
			if (h.mode == MODE_DEL_PERM && $urandom_range(0, 1))
				h.mode = MODE_ADD_REC;
			if ($urandom_range(0, 40) == 0)
				h.mode = 3'($urandom_range(5, 7));
			h.flen = 16'($urandom);
			h.proto = 8'($urandom);
		end else begin
			h.mode = MODE_PKT;
			case ($urandom_range(0, 9))
				0: h.flen = 16'($urandom_range(0, 90));
				1: h.flen = 16'hFFFF;
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0: h.etype = 16'($urandom);
				1: h.etype = ETYPE_V4;
				2: h.etype = ETYPE_V6;
				default: ;
			endcase
			case ($urandom_range(0, 5))
				0: h.proto = PROTO_ICMP;
				1: h.proto = PROTO_ICMP6;
				2, 3: h.proto = PROTO_TCP;
				4: h.proto = 8'($urandom);
				default: ;
			endcase
		end
		return h;
	endfunction

	task automatic test_directed();
		hdr_t h;
		logic [63:0] a4, b4, v6h, v6l;
		a4 = 64'h0000_0000_0A00_0001;
		b4 = 64'h0000_0000_C0A8_0102;
		v6h = 64'h2001_0DB8_0000_0001;
		v6l = 64'hFFFF_FFFF_FFFF_FFFF;
		// short Ethernet frame at both ends
		send_item(mk(MODE_PKT, 16'd0, ETYPE_V4, PROTO_UDP, '0, a4, 0));
		send_item(mk(MODE_PKT, 16'd13, ETYPE_V4, PROTO_UDP, '0, a4, 0));
		// other ethertype, short IPv4 and IPv6 headers
		send_item(mk(MODE_PKT, 16'hFFFF, 16'hFFFF, PROTO_UDP, '0, a4, 0));
		send_item(mk(MODE_PKT, 16'd33, ETYPE_V4, PROTO_UDP, '0, a4, 0));
		send_item(mk(MODE_PKT, 16'd53, ETYPE_V6, PROTO_UDP, v6h, v6l, 1));
		// unlisted, then permanent ban with junk in the ignored upper bits
		send_item(mk(MODE_PKT, 16'd34, ETYPE_V4, PROTO_TCP, '1, a4, 0));
		send_item(mk(MODE_ADD_PERM, 16'd0, 16'd0, 8'd0, '1, {32'hFFFF_FFFF, a4[31:0]}, 0));
		send_item(mk(MODE_ADD_PERM, 16'd0, 16'd0, 8'd0, '0, a4, 0));
		send_item(mk(MODE_PKT, 16'd1500, ETYPE_V4, PROTO_TCP, '0, a4, 0));
		// both marks set: permanent decides
		send_item(mk(MODE_ADD_REC, 16'd0, 16'd0, 8'd0, '0, a4, 0));
		send_item(mk(MODE_PKT, 16'd1500, ETYPE_V4, PROTO_UDP, '0, a4, 0));
		// recent paths on an IPv4 source
		send_item(mk(MODE_ADD_REC, 16'd0, 16'd0, 8'd0, '0, b4, 0));
		h = mk(MODE_PKT, 16'd54, ETYPE_V4, PROTO_UDP, '0, b4, 0);
		h.dport = dns_port;
		send_item(h);            // DNS on a recent source
		send_item(mk(MODE_PKT, 16'd41, ETYPE_V4, PROTO_UDP, '0, b4, 0)); // short UDP
		send_item(mk(MODE_DEL_PERM, 16'd0, 16'd0, 8'd0, '0, b4, 0));
		send_item(mk(MODE_ADD_REC, 16'd0, 16'd0, 8'd0, '0, b4, 0));
		h = mk(MODE_PKT, 16'd53, ETYPE_V4, PROTO_TCP, '0, b4, 0);
		h.fin = 1;
		send_item(h);            // short TCP header, no promotion
		h.flen = 16'd54;
		h.fin = 0;
		h.rst = 1;
		send_item(h);            // TCP RST promotes and passes
		// IPv6: recent ICMPv6, DNS bypass by source port, loopback
		send_item(mk(MODE_ADD_REC, 16'd0, 16'd0, 8'd0, v6h, v6l, 1));
		h = mk(MODE_PKT, 16'd62, ETYPE_V6, PROTO_UDP, v6h, v6l, 1);
		h.sport = dns_port;
		send_item(h);
		send_item(mk(MODE_PKT, 16'd60, ETYPE_V6, PROTO_ICMP6, v6h, v6l, 1));
		send_item(mk(MODE_PKT, 16'd60, ETYPE_V6, PROTO_UDP, 64'd0, 64'd1, 0));
		// remove of absent mark, unknown modes
		send_item(mk(MODE_DEL_REC, 16'd0, 16'd0, 8'd0, '0, a4, 1));
		send_item(mk(3'd7, 16'hFFFF, ETYPE_V4, 8'hFF, '1, '1, 1));
		send_item(mk(3'd5, 16'd0, 16'd0, 8'd0, '0, a4, 0));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_item());
	endtask

	// Receiver holds off long while the sender keeps offering items
	task automatic test_backpressure();
		go_idle();
		no_gaps = 1;
		hold_cycles = 400;
		test_random(40);
		no_gaps = 0;
	endtask

	task automatic test_dns_port();
		write_dns_port(16'd0);
		test_random(150);
		write_dns_port(16'hFFFF);
		test_random(150);
		write_dns_port(16'($urandom));
		test_random(150);
		write_dns_port(DNS_PORT_RST);
	endtask

	// Fill the ban table to overflow with fresh IPv6 sources; runs last
	task automatic test_table_full();
		for (int i = 0; i < NBAN + 4; i++)
			send_item(mk(MODE_ADD_PERM, 16'd0, 16'd0, 8'd0, 64'hFEED_0000_0000_0000,
				64'(i), 1));
		send_item(mk(MODE_PKT, 16'd100, ETYPE_V6, PROTO_TCP, 64'hFEED_0000_0000_0000,
			64'd3, 1));
	endtask

	initial begin
		for (int i = 0; i < NBAN; i++)
			ban_tag[i] = '0;
		for (int i = 0; i < NTRACK; i++) begin
			trk_vf[i] = '0;
			trk_age[i] = 0;
		end
		for (int i = 0; i < 4; i++)
			class_hits[i] = '0;
		processed_tot = '0;
		dropped_tot = '0;
		dns_port = DNS_PORT_RST;
		for (int i = 0; i < POOL; i++) begin
			pool_v6[i] = (i >= 12);
			pool_hi[i] = (i >= 12) ? {$urandom, $urandom} : 64'd0;
			pool_lo[i] = (i >= 12) ? {$urandom, $urandom} : {32'd0, $urandom};
		end
		pool_hi[23] = '0;            // IPv6 with zero upper half, not loopback
		pool_hi[POOL - 1] = '0;
		pool_lo[POOL - 1] = 64'd1;
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		test_directed();
		test_random(150);
		test_backpressure();
		test_dns_port();
		test_random(250);
		test_backpressure();
		test_table_full();

		in_valid = 0;
		wait (pending.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
